// ===== sv/fsfl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fsfl_pkg;

   localparam int SLOTS       = 32;
   localparam int RECORD_BITS = 64;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int COUNT_W     = $clog2(SLOTS + 1);
   localparam int POS_W       = 5;
   localparam int PAYLOAD_W   = 64;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2,
      OP_LIST   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_RANGE   = 3'd1,
      ST_DELETED = 3'd2,
      ST_FULL    = 3'd3,
      ST_NONE    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_EXEC = 2'd1,
      FSM_LIST = 2'd2
   } fsm_type;

   typedef struct packed {
      op_type                 op;
      logic [POS_W-1:0]       pos;
      logic [PAYLOAD_W-1:0]   payload;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [POS_W-1:0]       slot;
      logic [PAYLOAD_W-1:0]   record_out;
      logic                   last;
   } rsp_type;

   // link entry: live bit, link valid bit, next free slot
   typedef struct packed {
      logic                   live;
      logic                   nxt_vld;
      logic [SLOT_W-1:0]      nxt;
   } link_type;

endpackage
`default_nettype wire

// ===== sv/fixed_slot_free_list_store_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// add, delete and read: the exec state, then a registered result; no new word while busy
// list: accept, a read of each used slot, the read return, then the last word
// throughput set by the single read-modify-write pass through the slot memories
// reset (synchronous, active high) empties the store: no slots used, free list empty
// results are strobed for one cycle; the receiver cannot stall
module fixed_slot_free_list_store_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire fsfl_pkg::req_type req_word,
   output logic                  rsp_strobe,
   output fsfl_pkg::rsp_type     rsp_word
);

   localparam int SW = fsfl_pkg::SLOT_W;
   localparam int CW = fsfl_pkg::COUNT_W;
   localparam int RB = fsfl_pkg::RECORD_BITS;

   // slot memories, payload and link/live word, registered read
   logic [RB-1:0]          pay_mem [fsfl_pkg::SLOTS];
   fsfl_pkg::link_type     link_mem [fsfl_pkg::SLOTS];
   logic [RB-1:0]          pay_rd_ff;
   fsfl_pkg::link_type     link_rd_ff;

   logic                   rd_en;
   logic [SW-1:0]          rd_addr;
   logic                   pay_we;
   logic                   link_we;
   logic [SW-1:0]          wr_addr;
   logic [RB-1:0]          pay_wdata;
   fsfl_pkg::link_type     link_wdata;

   fsfl_pkg::fsm_type      state_ff, state_in;
   fsfl_pkg::req_type      req_ff, req_in;
   logic [SW-1:0]          head_ff, head_in;
   logic                   head_vld_ff, head_vld_in;
   logic [CW-1:0]          used_ff, used_in;

   // list walk: issue counter, read-in-flight tag, one held result for the last flag
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [SW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [SW-1:0]          pend_slot_ff, pend_slot_in;
   logic [RB-1:0]          pend_rec_ff, pend_rec_in;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   fsfl_pkg::rsp_type      rsp_ff, rsp_in;

   logic                   accept;
   logic                   issue;
   logic                   list_done;

   assign accept    = start && !busy;
   assign issue     = (state_ff == fsfl_pkg::FSM_LIST) && (cnt_ff < used_ff);
   assign list_done = (state_ff == fsfl_pkg::FSM_LIST) && (cnt_ff >= used_ff) && !rd_vld_ff;

   // memories
   always_ff @(posedge clock) begin
      if (pay_we) begin
         pay_mem[wr_addr] <= pay_wdata;
      end
      if (link_we) begin
         link_mem[wr_addr] <= link_wdata;
      end
      if (rd_en) begin
         pay_rd_ff  <= pay_mem[rd_addr];
         link_rd_ff <= link_mem[rd_addr];
      end
   end

   // read port: free head for add, pos for delete/read, walk counter for list
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = req_word.pos[SW-1:0];
      if (state_ff == fsfl_pkg::FSM_LIST) begin
         rd_en   = issue;
         rd_addr = cnt_ff[SW-1:0];
      end else if (accept) begin
         rd_en   = 1'b1;
         rd_addr = (req_word.op == fsfl_pkg::OP_ADD) ? head_ff : req_word.pos[SW-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsfl_pkg::FSM_IDLE: begin
            if (accept) begin
               state_in = (req_word.op == fsfl_pkg::OP_LIST) ? fsfl_pkg::FSM_LIST
                                                             : fsfl_pkg::FSM_EXEC;
            end
         end
         fsfl_pkg::FSM_EXEC: state_in = fsfl_pkg::FSM_IDLE;
         fsfl_pkg::FSM_LIST: begin
            if (list_done) begin
               state_in = fsfl_pkg::FSM_IDLE;
            end
         end
         default: state_in = fsfl_pkg::FSM_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy       = (state_ff != fsfl_pkg::FSM_IDLE);
      rsp_strobe = rsp_strobe_ff;
      rsp_word   = rsp_ff;
   end

   // datapath: read-modify-write of one slot, or one step of the list walk
   always_comb begin
      logic [SW-1:0] s;
      logic          ok;
      s             = '0;
      ok            = 1'b0;
      req_in        = req_ff;
      head_in       = head_ff;
      head_vld_in   = head_vld_ff;
      used_in       = used_ff;
      cnt_in        = cnt_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      pend_vld_in   = pend_vld_ff;
      pend_slot_in  = pend_slot_ff;
      pend_rec_in   = pend_rec_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      pay_we        = 1'b0;
      link_we       = 1'b0;
      wr_addr       = req_ff.pos[SW-1:0];
      pay_wdata     = req_ff.payload[RB-1:0];
      link_wdata    = '{live: 1'b1, nxt_vld: 1'b0, nxt: '0};

      if (accept) begin
         req_in      = req_word;
         cnt_in      = '0;
         pend_vld_in = 1'b0;
      end

      case (state_ff)
         fsfl_pkg::FSM_EXEC: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.record_out = '0;
            rsp_in.last       = 1'b1;
            rsp_in.slot       = req_ff.pos;
            rsp_in.status     = fsfl_pkg::ST_OK;
            if (req_ff.op == fsfl_pkg::OP_ADD) begin
               if (head_vld_ff) begin
                  s           = head_ff;
                  head_in     = link_rd_ff.nxt;
                  head_vld_in = link_rd_ff.nxt_vld;
                  ok          = 1'b1;
               end else if (used_ff < CW'(fsfl_pkg::SLOTS)) begin
                  s       = used_ff[SW-1:0];
                  used_in = used_ff + CW'(1);
                  ok      = 1'b1;
               end
               if (ok) begin
                  wr_addr     = s;
                  pay_we      = 1'b1;
                  link_we     = 1'b1;
                  rsp_in.slot = fsfl_pkg::POS_W'(s);
               end else begin
                  rsp_in.status = fsfl_pkg::ST_FULL;
                  rsp_in.slot   = '0;
               end
            end else if (CW'(req_ff.pos) >= used_ff) begin
               rsp_in.status = fsfl_pkg::ST_RANGE;
            end else if (!link_rd_ff.live) begin
               rsp_in.status = fsfl_pkg::ST_DELETED;
            end else if (req_ff.op == fsfl_pkg::OP_READ) begin
               rsp_in.record_out = fsfl_pkg::PAYLOAD_W'(pay_rd_ff);
            end else begin
               // delete: push the slot on the free list
               link_we     = 1'b1;
               link_wdata  = '{live: 1'b0, nxt_vld: head_vld_ff, nxt: head_ff};
               head_in     = req_ff.pos[SW-1:0];
               head_vld_in = 1'b1;
            end
         end
         fsfl_pkg::FSM_LIST: begin
            if (issue) begin
               cnt_in    = cnt_ff + CW'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[SW-1:0];
            end
            // a live slot releases the one held before it, not yet last
            if (rd_vld_ff && link_rd_ff.live) begin
               if (pend_vld_ff) begin
                  rsp_strobe_in     = 1'b1;
                  rsp_in.status     = fsfl_pkg::ST_OK;
                  rsp_in.slot       = fsfl_pkg::POS_W'(pend_slot_ff);
                  rsp_in.record_out = fsfl_pkg::PAYLOAD_W'(pend_rec_ff);
                  rsp_in.last       = 1'b0;
               end
               pend_vld_in  = 1'b1;
               pend_slot_in = rd_idx_ff;
               pend_rec_in  = pay_rd_ff;
            end
            if (list_done) begin
               rsp_strobe_in = 1'b1;
               rsp_in.last   = 1'b1;
               pend_vld_in   = 1'b0;
               if (pend_vld_ff) begin
                  rsp_in.status     = fsfl_pkg::ST_OK;
                  rsp_in.slot       = fsfl_pkg::POS_W'(pend_slot_ff);
                  rsp_in.record_out = fsfl_pkg::PAYLOAD_W'(pend_rec_ff);
               end else begin
                  rsp_in.status     = fsfl_pkg::ST_NONE;
                  rsp_in.slot       = '0;
                  rsp_in.record_out = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fsfl_pkg::FSM_IDLE;
         head_vld_ff   <= 1'b0;
         used_ff       <= '0;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_vld_ff   <= head_vld_in;
         used_ff       <= used_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= rd_vld_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      head_ff      <= head_in;
      rd_idx_ff    <= rd_idx_in;
      pend_slot_ff <= pend_slot_in;
      pend_rec_ff  <= pend_rec_in;
      rsp_ff       <= rsp_in;
   end

`ifndef SYNTHESIS
   // the free list only ever points at slots already in use
   assert property (@(posedge clock) disable iff (reset)
      head_vld_ff |-> (CW'(head_ff) < used_ff))
      else $error("free list head beyond used slots");

   // every failure is a single, final word with no record
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_word.status != fsfl_pkg::ST_OK))
         |-> (rsp_word.last && (rsp_word.record_out == '0)))
      else $error("error word not final or carries a record");

   // a single-slot op answers with a final word, registered after the exec state that follows acceptance
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_word.op != fsfl_pkg::OP_LIST)) |=> ##1 (rsp_strobe && rsp_word.last))
      else $error("missing result for single-slot op");

   // used count never exceeds capacity
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(fsfl_pkg::SLOTS))
      else $error("used slot count overflow");
`endif

endmodule
`default_nettype wire
